[rtl/trd_pkg.sv]
// Shared types and codes for the telematics record deframer.
package trd_pkg;

  localparam int unsigned LenW  = 16;
  localparam int unsigned NumW  = 16;
  localparam int unsigned ByteW = 8;
  localparam int unsigned KindW = 2;

  localparam logic [LenW-1:0] MaxLenReset = 16'hFFFF;

  typedef enum logic [KindW-1:0] {
    KIND_HEADER = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_ERROR  = 2'd2
  } trd_kind_e;

  typedef struct packed {
    trd_kind_e        kind;
    logic [LenW-1:0]  rec_len;
    logic [NumW-1:0]  rec_num;
    logic [ByteW-1:0] source_service;
    logic [ByteW-1:0] recipient_service;
    logic [ByteW-1:0] data_byte;
    logic             last_of_record;
  } trd_res_t;

endpackage

[rtl/trd_cfg.sv]
// APB register file holding the maximum record length.
module trd_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output logic [trd_pkg::LenW-1:0]  max_len_o
);
  import trd_pkg::*;

  localparam logic RegMaxLen = 1'b0;

  logic [LenW-1:0] max_len_q, max_len_d;
  logic            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == RegMaxLen);

  always_comb begin
    max_len_d = max_len_q;
    if (wr_en) begin
      max_len_d = pwdata[LenW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenReset;
    end else begin
      max_len_q <= max_len_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == RegMaxLen) begin
      prdata = {{(32-LenW){1'b0}}, max_len_q};
    end
  end

  assign max_len_o = max_len_q;
endmodule

[rtl/trd_parser.sv]
// Record header parser: per-byte state update and result decode.
module trd_parser (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [trd_pkg::ByteW-1:0]  byte_i,
  input  logic                       end_i,
  input  logic [trd_pkg::LenW-1:0]   max_len_i,
  output logic                       res_vld_o,
  output trd_pkg::trd_res_t          res_o
);
  import trd_pkg::*;

  localparam logic [3:0] PH_LEN_LO = 4'd0;
  localparam logic [3:0] PH_LEN_HI = 4'd1;
  localparam logic [3:0] PH_NUM_LO = 4'd2;
  localparam logic [3:0] PH_NUM_HI = 4'd3;
  localparam logic [3:0] PH_FLAGS  = 4'd4;
  localparam logic [3:0] PH_SKIP   = 4'd5;
  localparam logic [3:0] PH_SRC    = 4'd6;
  localparam logic [3:0] PH_RCP    = 4'd7;
  localparam logic [3:0] PH_DATA   = 4'd8;

  logic [3:0]       phase_q, phase_d;
  logic [1:0]       skip_q, skip_d;
  logic [2:0]       flags_q, flags_d;
  logic [2:0]       flags_clr;
  logic [LenW-1:0]  len_q, len_d;
  logic [NumW-1:0]  num_q, num_d;
  logic [ByteW-1:0] src_q, src_d;
  logic [ByteW-1:0] rcp_q, rcp_d;
  logic [LenW-1:0]  left_q, left_d;
  logic             disc_q, disc_d;
  logic             in_hdr;
  logic             err;
  logic             emit;
  trd_kind_e        kind;
  logic [ByteW-1:0] dbyte;
  logic             last;

  assign flags_clr = flags_q & (flags_q - 3'd1);

  always_comb begin
    phase_d = phase_q;
    skip_d  = skip_q;
    flags_d = flags_q;
    len_d   = len_q;
    num_d   = num_q;
    src_d   = src_q;
    rcp_d   = rcp_q;
    left_d  = left_q;
    disc_d  = disc_q;
    in_hdr  = 1'b0;
    err     = 1'b0;
    emit    = 1'b0;
    kind    = KIND_HEADER;
    dbyte   = '0;
    last    = 1'b0;
    if (disc_q) begin
      if (end_i) begin
        disc_d  = 1'b0;
        phase_d = PH_LEN_LO;
      end
    end else begin
      unique case (phase_q)
        PH_LEN_LO: begin
          len_d   = {8'h00, byte_i};
          phase_d = PH_LEN_HI;
          in_hdr  = 1'b1;
        end
        PH_LEN_HI: begin
          len_d = {byte_i, len_q[7:0]};
          if ({byte_i, len_q[7:0]} > max_len_i) begin
            err     = 1'b1;
            disc_d  = !end_i;
            phase_d = PH_LEN_LO;
          end else begin
            phase_d = PH_NUM_LO;
            in_hdr  = 1'b1;
          end
        end
        PH_NUM_LO: begin
          num_d   = {8'h00, byte_i};
          phase_d = PH_NUM_HI;
          in_hdr  = 1'b1;
        end
        PH_NUM_HI: begin
          num_d   = {byte_i, num_q[7:0]};
          phase_d = PH_FLAGS;
          in_hdr  = 1'b1;
        end
        PH_FLAGS: begin
          flags_d = byte_i[2:0];
          skip_d  = 2'd0;
          phase_d = (|byte_i[2:0]) ? PH_SKIP : PH_SRC;
          in_hdr  = 1'b1;
        end
        PH_SKIP: begin
          skip_d = skip_q + 2'd1;
          if (skip_q == 2'd3) begin
            flags_d = flags_clr;
            phase_d = (|flags_clr) ? PH_SKIP : PH_SRC;
          end
          in_hdr = 1'b1;
        end
        PH_SRC: begin
          src_d   = byte_i;
          phase_d = PH_RCP;
          in_hdr  = 1'b1;
        end
        PH_RCP: begin
          rcp_d   = byte_i;
          left_d  = len_q;
          phase_d = PH_LEN_LO;
          if (len_q == '0) begin
            emit = 1'b1;
            last = 1'b1;
          end else if (end_i) begin
            err = 1'b1;
          end else begin
            emit    = 1'b1;
            phase_d = PH_DATA;
          end
        end
        PH_DATA: begin
          kind  = KIND_DATA;
          dbyte = byte_i;
          if (left_q <= 16'd1) begin
            left_d  = '0;
            emit    = 1'b1;
            last    = 1'b1;
            phase_d = PH_LEN_LO;
          end else begin
            left_d = left_q - 16'd1;
            if (end_i) begin
              err     = 1'b1;
              phase_d = PH_LEN_LO;
            end else begin
              emit = 1'b1;
            end
          end
        end
        default: begin
          phase_d = PH_LEN_LO;
        end
      endcase
      if (in_hdr && end_i) begin
        err     = 1'b1;
        phase_d = PH_LEN_LO;
      end
    end
  end

  always_comb begin
    res_vld_o = emit || err;
    res_o     = '0;
    if (err) begin
      res_o.kind = KIND_ERROR;
    end else begin
      res_o.kind              = kind;
      res_o.rec_len           = len_d;
      res_o.rec_num           = num_d;
      res_o.source_service    = src_d;
      res_o.recipient_service = rcp_d;
      res_o.data_byte         = dbyte;
      res_o.last_of_record    = last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEN_LO;
      skip_q  <= '0;
      flags_q <= '0;
      len_q   <= '0;
      num_q   <= '0;
      src_q   <= '0;
      rcp_q   <= '0;
      left_q  <= '0;
      disc_q  <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      skip_q  <= skip_d;
      flags_q <= flags_d;
      len_q   <= len_d;
      num_q   <= num_d;
      src_q   <= src_d;
      rcp_q   <= rcp_d;
      left_q  <= left_d;
      disc_q  <= disc_d;
    end
  end
endmodule

[rtl/telematics_record_deframer.sv]
// Top level of the telematics record deframer: input stage, parser, result register.
//
//  port group | dir | word
//  -----------+-----+-------------------------------------------------
//  s_axis     | in  | one buffer byte, tlast marks the buffer end
//  m_axis     | out | header, data byte or error; tlast ends a record
//  apb        | in  | max_record_length at byte address 0
//
// One word per cycle sustained while m_axis is not stalled; a byte passes the
// input register, then the result register, on its way to m_axis. Parser state
// updates in the same cycle a byte leaves the input register. Reset clears
// control state and sets the maximum length to 65535. A stalled m_axis holds
// its word; s_axis still takes one more word into the input register meanwhile.
module telematics_record_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // in_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // rec_len, rec_num, source_service, recipient_service, data_byte
  output logic [55:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,   // kind
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import trd_pkg::*;

  logic             in_vld_q, in_vld_d;
  logic [ByteW-1:0] in_byte_q;
  logic             in_end_q;
  logic             out_vld_q, out_vld_d;
  trd_res_t         out_res_q;
  trd_res_t         res;
  logic             res_vld;
  logic             adv;
  logic             s_acc;
  logic [LenW-1:0]  max_len;

  trd_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .max_len_o (max_len)
  );

  trd_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (adv),
    .byte_i    (in_byte_q),
    .end_i     (in_end_q),
    .max_len_i (max_len),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (s_acc) begin
      in_vld_d = 1'b1;
    end else if (adv) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = adv ? res_vld : (out_vld_q && !m_axis_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_byte_q <= s_axis_tdata;
      in_end_q  <= s_axis_tlast;
    end
    if (adv && res_vld) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_res_q.kind;
  assign m_axis_tlast  = out_res_q.last_of_record;
  assign m_axis_tdata  = {out_res_q.data_byte, out_res_q.recipient_service,
                          out_res_q.source_service, out_res_q.rec_num,
                          out_res_q.rec_len};
endmodule
